[design/owbm_pkg.sv]
// Shared types, timing defaults and CRC helper for the one-wire byte master.
`timescale 1ns / 1ps
package owbm_pkg;

  localparam int unsigned NumCfg   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned TimeW    = 10;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_RESET_WAIT    = 3'd1,
    REG_RESET_TAIL    = 3'd2,
    REG_SLOT_LOW      = 3'd3,
    REG_WRITE_HOLD    = 3'd4,
    REG_WRITE_RECOVER = 3'd5,
    REG_READ_RELEASE  = 3'd6,
    REG_READ_TAIL     = 3'd7
  } cfg_reg_e;

  // Command codes carried in the mode field
  typedef enum logic [1:0] {
    CMD_RESET  = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_RST_LOW    = 3'd1,
    PH_RST_WAIT   = 3'd2,
    PH_RST_TAIL   = 3'd3,
    PH_SLOT_LOW   = 3'd4,
    PH_WRITE_HOLD = 3'd5,
    PH_READ_REL   = 3'd6,
    PH_SLOT_TAIL  = 3'd7
  } phase_e;

  localparam logic [9:0] ResetLowDflt  = 10'd750;
  localparam logic [9:0] ResetWaitDflt = 10'd202;
  localparam logic [9:0] ResetTailDflt = 10'd300;
  localparam logic [3:0] SlotLowDflt   = 4'd2;
  localparam logic [6:0] WrHoldDflt    = 7'd65;
  localparam logic [5:0] WrRecoverDflt = 6'd15;
  localparam logic [3:0] RdReleaseDflt = 4'd2;
  localparam logic [6:0] RdTailDflt    = 7'd60;

  localparam logic [7:0] CrcPoly = 8'h8C;

  typedef struct packed {
    logic [9:0] reset_low_us;
    logic [9:0] reset_wait_us;
    logic [9:0] reset_tail_us;
    logic [3:0] slot_low_us;
    logic [6:0] write_hold_us;
    logic [5:0] write_recover_us;
    logic [3:0] read_release_us;
    logic [6:0] read_tail_us;
  } cfg_t;

  typedef struct packed {
    logic       start_req;
    logic [1:0] mode;
    logic [7:0] tx_byte;
    logic       crc_clear;
    logic       line_level;
  } in_word_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       presence;
    logic [7:0] crc_value;
    logic       crc_zero;
  } out_word_t;

  // Dallas CRC-8, reflected, one byte LSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = {1'b0, c[7:1]};
      if (fb) begin
        c = c ^ CrcPoly;
      end
    end
    return c;
  endfunction

endpackage

[design/owbm_if.sv]
// Valid/ready channel interfaces for tick input words and result words.
`timescale 1ns / 1ps
interface owbm_in_if;
  import owbm_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface owbm_out_if;
  import owbm_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[design/owbm_cfg_regs.sv]
// Slot timing register file written through the plain configuration port.
`timescale 1ns / 1ps
module owbm_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [owbm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [owbm_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output owbm_pkg::cfg_t                   cfg_o
);
  import owbm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_RESET_LOW:     cfg_d.reset_low_us     = cfg_wdata_i;
        REG_RESET_WAIT:    cfg_d.reset_wait_us    = cfg_wdata_i;
        REG_RESET_TAIL:    cfg_d.reset_tail_us    = cfg_wdata_i;
        REG_SLOT_LOW:      cfg_d.slot_low_us      = cfg_wdata_i[3:0];
        REG_WRITE_HOLD:    cfg_d.write_hold_us    = cfg_wdata_i[6:0];
        REG_WRITE_RECOVER: cfg_d.write_recover_us = cfg_wdata_i[5:0];
        REG_READ_RELEASE:  cfg_d.read_release_us  = cfg_wdata_i[3:0];
        REG_READ_TAIL:     cfg_d.read_tail_us     = cfg_wdata_i[6:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low_us     <= ResetLowDflt;
      cfg_q.reset_wait_us    <= ResetWaitDflt;
      cfg_q.reset_tail_us    <= ResetTailDflt;
      cfg_q.slot_low_us      <= SlotLowDflt;
      cfg_q.write_hold_us    <= WrHoldDflt;
      cfg_q.write_recover_us <= WrRecoverDflt;
      cfg_q.read_release_us  <= RdReleaseDflt;
      cfg_q.read_tail_us     <= RdTailDflt;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/owbm_engine.sv]
// Per-tick bus sequencer: phase timer, bit shifter, presence and CRC state.
`timescale 1ns / 1ps
module owbm_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  owbm_pkg::in_word_t   word_i,
  input  owbm_pkg::cfg_t       cfg_i,
  output owbm_pkg::out_word_t  res_o
);
  import owbm_pkg::*;

  phase_e           phase_q, phase_d;
  cmd_e             cmd_q, cmd_d;
  logic [TimeW-1:0] tl_q, tl_d;
  logic [2:0]       bits_q, bits_d;
  logic [7:0]       shift_q, shift_d;
  logic [7:0]       crc_q, crc_d;
  logic             pres_q, pres_d;
  logic [7:0]       rx_q, rx_d;

  // state as seen after a possible command start on this tick
  phase_e           ph_s;
  cmd_e             cmd_s;
  logic [TimeW-1:0] tl_s;
  logic [2:0]       bits_s;
  logic [7:0]       shift_s;
  logic [7:0]       crc_s;
  logic             start;
  logic             last;

  logic drive, busy, done;

  function automatic logic [TimeW-1:0] dur(input phase_e p, input cmd_e c, input cfg_t cfg);
    logic [TimeW-1:0] d;
    d = '0;
    unique case (p)
      PH_RST_LOW:    d = cfg.reset_low_us;
      PH_RST_WAIT:   d = cfg.reset_wait_us;
      PH_RST_TAIL:   d = cfg.reset_tail_us;
      PH_SLOT_LOW:   d = TimeW'(cfg.slot_low_us);
      PH_WRITE_HOLD: d = TimeW'(cfg.write_hold_us);
      PH_READ_REL:   d = TimeW'(cfg.read_release_us);
      PH_SLOT_TAIL:  d = (c == CMD_WRITE) ? TimeW'(cfg.write_recover_us)
                                          : TimeW'(cfg.read_tail_us);
      default:       d = '0;
    endcase
    return d;
  endfunction

  assign start = (phase_q == PH_IDLE) && word_i.start_req && (cmd_e'(word_i.mode) != CMD_UNUSED);

  always_comb begin
    ph_s    = phase_q;
    cmd_s   = cmd_q;
    tl_s    = tl_q;
    bits_s  = bits_q;
    shift_s = shift_q;
    crc_s   = crc_q;
    if (start) begin
      cmd_s   = cmd_e'(word_i.mode);
      bits_s  = '0;
      shift_s = (cmd_s == CMD_WRITE) ? word_i.tx_byte : 8'h00;
      ph_s    = (cmd_s == CMD_RESET) ? PH_RST_LOW : PH_SLOT_LOW;
      tl_s    = dur(ph_s, cmd_s, cfg_i);
      if (word_i.crc_clear) begin
        crc_s = 8'h00;
      end
    end
  end

  assign last = (tl_s <= TimeW'(1));

  // next state
  always_comb begin
    phase_d = ph_s;
    cmd_d   = cmd_s;
    tl_d    = tl_s;
    bits_d  = bits_s;
    shift_d = shift_s;
    crc_d   = crc_s;
    pres_d  = pres_q;
    rx_d    = rx_q;
    if (ph_s != PH_IDLE) begin
      if (!last) begin
        tl_d = tl_s - TimeW'(1);
      end else begin
        unique case (ph_s)
          PH_RST_LOW: begin
            phase_d = PH_RST_WAIT;
            tl_d    = dur(PH_RST_WAIT, cmd_s, cfg_i);
          end
          PH_RST_WAIT: begin
            pres_d  = word_i.line_level;
            phase_d = PH_RST_TAIL;
            tl_d    = dur(PH_RST_TAIL, cmd_s, cfg_i);
          end
          PH_RST_TAIL: begin
            phase_d = PH_IDLE;
            tl_d    = '0;
          end
          PH_SLOT_LOW: begin
            phase_d = (cmd_s == CMD_WRITE) ? PH_WRITE_HOLD : PH_READ_REL;
            tl_d    = dur(phase_d, cmd_s, cfg_i);
          end
          PH_WRITE_HOLD: begin
            shift_d = {shift_s[0], shift_s[7:1]};
            phase_d = PH_SLOT_TAIL;
            tl_d    = dur(PH_SLOT_TAIL, cmd_s, cfg_i);
          end
          PH_READ_REL: begin
            shift_d = {word_i.line_level, shift_s[7:1]};
            phase_d = PH_SLOT_TAIL;
            tl_d    = dur(PH_SLOT_TAIL, cmd_s, cfg_i);
          end
          PH_SLOT_TAIL: begin
            if (bits_s == 3'd7) begin
              crc_d = crc8_byte(crc_s, shift_s);
              if (cmd_s == CMD_READ) begin
                rx_d = shift_s;
              end
              phase_d = PH_IDLE;
              tl_d    = '0;
            end else begin
              bits_d  = bits_s + 3'd1;
              phase_d = PH_SLOT_LOW;
              tl_d    = dur(PH_SLOT_LOW, cmd_s, cfg_i);
            end
          end
          default: phase_d = ph_s;
        endcase
      end
    end
  end

  // per-tick outputs
  always_comb begin
    drive = 1'b0;
    busy  = (ph_s != PH_IDLE);
    done  = 1'b0;
    unique case (ph_s) inside
      PH_RST_LOW, PH_SLOT_LOW: drive = 1'b1;
      PH_WRITE_HOLD:           drive = ~shift_s[0];
      PH_RST_TAIL:             done  = last;
      PH_SLOT_TAIL:            done  = last && (bits_s == 3'd7);
      default:                 drive = 1'b0;
    endcase
  end

  always_comb begin
    res_o.drive_low = drive;
    res_o.busy_res  = busy;
    res_o.done_res  = done;
    res_o.rx_byte   = rx_d;
    res_o.presence  = pres_d;
    res_o.crc_value = crc_d;
    res_o.crc_zero  = (crc_d == 8'h00);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cmd_q   <= CMD_RESET;
      tl_q    <= '0;
      bits_q  <= '0;
      shift_q <= '0;
      crc_q   <= '0;
      pres_q  <= 1'b0;
      rx_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      tl_q    <= tl_d;
      bits_q  <= bits_d;
      shift_q <= shift_d;
      crc_q   <= crc_d;
      pres_q  <= pres_d;
      rx_q    <= rx_d;
    end
  end

endmodule

[design/one_wire_byte_master_crc8_core.sv]
// Top level of the bit-timed one-wire byte master with running CRC-8.
`timescale 1ns / 1ps
// Usage:
//  - in_ch carries one word per microsecond of bus time: start request, mode,
//    byte to send, CRC clear and the sampled line level.
//  - out_ch returns exactly one word per input word: drive_low for that tick,
//    busy/done flags, last read byte, presence flag and the running CRC.
//  - cfg_we_i/cfg_idx_i/cfg_wdata_i write the eight slot timing registers;
//    write only while no command is running and all results are drained.
// Timing:
//  - A result word is valid the cycle after its input word is accepted
//    and one word can be accepted every cycle unless the output register stalls.
//  - The per-tick sequencer updates its state in the accepting cycle, so the
//    next tick may follow directly; the critical path is the CRC byte update.
// Reset: rst_ni clears the sequencer to idle, CRC/presence/rx to zero and the
//  timing registers to their defaults (750, 202, 300, 2, 65, 15, 2, 60 us).
// Stall: a single output register holds the pending result; while it is full
//  and out_ch.ready is low, in_ch.ready is low and no tick is consumed.
module one_wire_byte_master_crc8_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  owbm_in_if.sink                       in_ch,
  owbm_out_if.source                    out_ch,
  input  logic                          cfg_we_i,
  input  logic [owbm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [owbm_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import owbm_pkg::*;

  cfg_t      cfg;
  out_word_t res;
  out_word_t out_q;
  logic      out_vld_q, out_vld_d;
  logic      accept;

  owbm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  owbm_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .word_i (in_ch.data),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // take a new tick whenever the output slot is empty or being drained
  assign in_ch.ready = !out_vld_q || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    out_vld_d = out_vld_q;
    if (accept) begin
      out_vld_d = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_ch.valid = out_vld_q;
  assign out_ch.data  = out_q;

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the bit-timed one-wire byte master with CRC-8.
`timescale 1ns / 1ps
module tb_top;
  import owbm_pkg::*;

  // Run control
  localparam int unsigned RandomTicks = 400;    // busy ticks in the random part
  localparam int unsigned RoundTicks  = 150;    // busy ticks between timing changes
  localparam int unsigned SettleTicks = 4;      // pause before a register write
  localparam int unsigned TailTicks   = 8;      // pause after the last result
  localparam int unsigned MaxPrinted  = 40;     // mismatch lines shown
  localparam longint unsigned WatchdogNs = 64'd4_000_000;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  owbm_in_if  in_ch ();
  owbm_out_if out_ch ();

  one_wire_byte_master_crc8_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Bus master shadow: timing registers and sequencer state, advanced once per
  // accepted tick word. Each tick yields exactly one expected result word.
  // ---------------------------------------------------------------------------
  cfg_t       m_cfg;
  phase_e     m_phase;
  cmd_e       m_cmd;
  logic [9:0] m_left;     // ticks remaining in the current phase
  logic [2:0] m_bit;      // slot index within the byte
  logic [7:0] m_shift;    // byte being sent or assembled
  logic [7:0] m_crc;
  logic       m_pres;
  logic [7:0] m_rx;

  out_word_t   expected_q[$];
  int unsigned err_count;
  int unsigned result_count;
  int unsigned busy_ticks;

  // Stimulus knobs
  bit         send_idle_on;
  bit         recv_idle_on;
  bit         bus_noise;    // line level random everywhere, even at sample points
  logic [7:0] bus_target;   // bits a slave returns on reads; bit 0 doubles as presence

  // Dallas CRC-8, reflected: fold the byte in, then eight shift steps
  function automatic logic [7:0] crc_absorb(input logic [7:0] acc, input logic [7:0] data);
    logic [7:0] s;
    s = acc ^ data;
    repeat (8) s = s[0] ? ((s >> 1) ^ CrcPoly) : (s >> 1);
    return s;
  endfunction

  function automatic logic [9:0] phase_len(input phase_e p);
    case (p)
      PH_RST_LOW:    return m_cfg.reset_low_us;
      PH_RST_WAIT:   return m_cfg.reset_wait_us;
      PH_RST_TAIL:   return m_cfg.reset_tail_us;
      PH_SLOT_LOW:   return 10'(m_cfg.slot_low_us);
      PH_WRITE_HOLD: return 10'(m_cfg.write_hold_us);
      PH_READ_REL:   return 10'(m_cfg.read_release_us);
      PH_SLOT_TAIL: begin
        if (m_cmd == CMD_WRITE) return 10'(m_cfg.write_recover_us);
        return 10'(m_cfg.read_tail_us);
      end
      default:       return '0;
    endcase
  endfunction

  function automatic void enter_phase(input phase_e p);
    m_phase = p;
    m_left  = phase_len(p);
  endfunction

  function automatic void shadow_reset();
    m_cfg = '{reset_low_us: ResetLowDflt, reset_wait_us: ResetWaitDflt,
              reset_tail_us: ResetTailDflt, slot_low_us: SlotLowDflt,
              write_hold_us: WrHoldDflt, write_recover_us: WrRecoverDflt,
              read_release_us: RdReleaseDflt, read_tail_us: RdTailDflt};
    m_phase = PH_IDLE;
    m_cmd   = CMD_RESET;
    m_left  = '0;
    m_bit   = '0;
    m_shift = '0;
    m_crc   = '0;
    m_pres  = 1'b0;
    m_rx    = '0;
  endfunction

  // One microsecond of bus time
  function automatic void predict_tick(input in_word_t w);
    out_word_t r;
    logic      last;
    logic      fin;
    r   = '0;
    fin = 1'b0;
    // A start taken while idle makes this very tick the first of the command
    if (m_phase == PH_IDLE && w.start_req && w.mode != CMD_UNUSED) begin
      if (w.crc_clear) m_crc = 8'h00;
      m_cmd   = cmd_e'(w.mode);
      m_bit   = '0;
      m_shift = (w.mode == CMD_WRITE) ? w.tx_byte : 8'h00;
      if (w.mode == CMD_RESET) enter_phase(PH_RST_LOW);
      else enter_phase(PH_SLOT_LOW);
    end
    if (m_phase != PH_IDLE) begin
      r.busy_res = 1'b1;
      busy_ticks++;
      // a zero-length phase still takes one tick
      last = (m_left <= 10'd1);
      if (!last) m_left = m_left - 10'd1;
      case (m_phase)
        PH_RST_LOW: begin
          r.drive_low = 1'b1;
          if (last) enter_phase(PH_RST_WAIT);
        end
        PH_RST_WAIT: begin
          if (last) begin
            m_pres = w.line_level;
            enter_phase(PH_RST_TAIL);
          end
        end
        PH_RST_TAIL: fin = last;
        PH_SLOT_LOW: begin
          r.drive_low = 1'b1;
          if (last) begin
            if (m_cmd == CMD_WRITE) enter_phase(PH_WRITE_HOLD);
            else enter_phase(PH_READ_REL);
          end
        end
        PH_WRITE_HOLD: begin
          r.drive_low = ~m_shift[0];
          if (last) begin
            m_shift = {m_shift[0], m_shift[7:1]};
            enter_phase(PH_SLOT_TAIL);
          end
        end
        PH_READ_REL: begin
          if (last) begin
            m_shift = {w.line_level, m_shift[7:1]};
            enter_phase(PH_SLOT_TAIL);
          end
        end
        default: begin
          if (last) begin
            // CRC only moves when the whole byte is done
            if (m_bit == 3'd7) begin
              m_crc = crc_absorb(m_crc, m_shift);
              if (m_cmd == CMD_READ) m_rx = m_shift;
              fin = 1'b1;
            end else begin
              m_bit = m_bit + 3'd1;
              enter_phase(PH_SLOT_LOW);
            end
          end
        end
      endcase
      if (fin) begin
        m_phase     = PH_IDLE;
        m_left      = '0;
        r.done_res  = 1'b1;
      end
    end
    r.rx_byte   = m_rx;
    r.presence  = m_pres;
    r.crc_value = m_crc;
    r.crc_zero  = (m_crc == 8'h00);
    expected_q.push_back(r);
  endfunction

  task automatic flag_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    if (err_count < MaxPrinted)
      $display("MISMATCH result %0d %s: got %0h want %0h", result_count, what, got, want);
    err_count++;
  endtask

  // Sample both channels at the rising edge: shadow first, then compare
  always @(posedge clk_i) begin : monitor
    out_word_t got;
    out_word_t want;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) predict_tick(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_q.size() == 0) begin
          flag_mismatch("unexpected word", got.crc_value, 8'h00);
        end else begin
          want = expected_q.pop_front();
          if (got.drive_low !== want.drive_low)
            flag_mismatch("drive_low", 8'(got.drive_low), 8'(want.drive_low));
          if (got.busy_res !== want.busy_res)
            flag_mismatch("busy_res", 8'(got.busy_res), 8'(want.busy_res));
          if (got.done_res !== want.done_res)
            flag_mismatch("done_res", 8'(got.done_res), 8'(want.done_res));
          if (got.rx_byte !== want.rx_byte)
            flag_mismatch("rx_byte", got.rx_byte, want.rx_byte);
          if (got.presence !== want.presence)
            flag_mismatch("presence", 8'(got.presence), 8'(want.presence));
          if (got.crc_value !== want.crc_value)
            flag_mismatch("crc_value", got.crc_value, want.crc_value);
          if (got.crc_zero !== want.crc_zero)
            flag_mismatch("crc_zero", 8'(got.crc_zero), 8'(want.crc_zero));
        end
        result_count++;
      end
    end
  end

  // Result side: random stall per word, released at the falling edge
  initial begin : result_sink
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = recv_idle_on ? $urandom_range(0, 6) : 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // ---------------------------------------------------------------------------
  // Tick driver. Every task below starts and ends just after a falling edge.
  // valid is left high after a word so back-to-back ticks need no toggle.
  // ---------------------------------------------------------------------------
  task automatic send_tick(input in_word_t w);
    int gap;
    gap = send_idle_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // Stop sending until every pending result has been returned
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
  endtask

  // What the slave side puts on the line for the next tick
  function automatic logic bus_line();
    if (bus_noise) return 1'($urandom_range(0, 1));
    case (m_phase)
      PH_RST_WAIT: return bus_target[0];
      PH_READ_REL: return bus_target[m_bit];
      default:     return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // Registers only change with the sequencer idle and the pipe empty
  task automatic load_timing(input cfg_t c);
    logic [9:0] v [NumCfg];
    cfg_reg_e   r;
    v[REG_RESET_LOW]     = c.reset_low_us;
    v[REG_RESET_WAIT]    = c.reset_wait_us;
    v[REG_RESET_TAIL]    = c.reset_tail_us;
    v[REG_SLOT_LOW]      = 10'(c.slot_low_us);
    v[REG_WRITE_HOLD]    = 10'(c.write_hold_us);
    v[REG_WRITE_RECOVER] = 10'(c.write_recover_us);
    v[REG_READ_RELEASE]  = 10'(c.read_release_us);
    v[REG_READ_TAIL]     = 10'(c.read_tail_us);
    drain_results();
    repeat (SettleTicks) @(negedge clk_i);
    r = r.first();
    do begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= r;
      cfg_wdata_i <= v[r];
      @(negedge clk_i);
      r = r.next();
    end while (r != r.first());
    cfg_we_i <= 1'b0;
    m_cfg = c;
  endtask

  task automatic idle_ticks(input int n);
    in_word_t w;
    repeat (n) begin
      w            = in_word_t'($urandom);
      w.start_req  = 1'b0;
      w.line_level = bus_line();
      send_tick(w);
    end
  endtask

  // Start one command and keep ticking until the shadow goes idle. Words sent while
  // busy carry random start/mode/byte/clear, which the block must ignore.
  task automatic run_command(input cmd_e cmd, input logic [7:0] payload, input logic clr,
                             input logic [7:0] bus_byte, input bit pause_mid);
    in_word_t w;
    int       n;
    send_idle_on = ($urandom_range(0, 3) != 0);
    recv_idle_on = ($urandom_range(0, 3) != 0);
    bus_target   = bus_byte;
    w            = in_word_t'($urandom);
    w.start_req  = 1'b1;
    w.mode       = cmd;
    w.tx_byte    = payload;
    w.crc_clear  = clr;
    w.line_level = bus_line();
    send_tick(w);
    n = 0;
    while (m_phase != PH_IDLE) begin
      w            = in_word_t'($urandom);
      w.line_level = bus_line();
      send_tick(w);
      n++;
      if (pause_mid && n == 5) drain_results();
    end
  endtask

  function automatic cfg_t short_timing();
    cfg_t c;
    c.reset_low_us     = 10'($urandom_range(0, 3));
    c.reset_wait_us    = 10'($urandom_range(0, 3));
    c.reset_tail_us    = 10'($urandom_range(0, 3));
    c.slot_low_us      = 4'($urandom_range(1, 3));
    c.write_hold_us    = 7'($urandom_range(1, 4));
    c.write_recover_us = 6'($urandom_range(1, 3));
    c.read_release_us  = 4'($urandom_range(1, 3));
    c.read_tail_us     = 7'($urandom_range(1, 4));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Power-on timing: idle ticks, then a read slot train on the default timing
  task automatic test_power_on_defaults();
    idle_ticks(3);
    run_command(CMD_READ, 8'h00, 1'b0, 8'hC3, 1'b0);
  endtask

  // Shortest phases: zero-length reset phases, one-tick slot phases. Covers both
  // presence levels, all-zero and all-one bytes, the unused mode, CRC clear and
  // a frame closed by its own CRC byte.
  task automatic test_short_timing();
    load_timing('{reset_low_us: 10'd0, reset_wait_us: 10'd0, reset_tail_us: 10'd0,
                  slot_low_us: 4'd1, write_hold_us: 7'd1, write_recover_us: 6'd1,
                  read_release_us: 4'd1, read_tail_us: 7'd1});
    run_command(CMD_RESET, 8'hFF, 1'b0, 8'h01, 1'b0);
    run_command(CMD_RESET, 8'hFF, 1'b1, 8'h00, 1'b0);
    run_command(CMD_UNUSED, 8'hFF, 1'b1, 8'h00, 1'b0);
    run_command(CMD_WRITE, 8'h00, 1'b0, 8'h00, 1'b0);
    run_command(CMD_WRITE, 8'hFF, 1'b0, 8'h00, 1'b1);
    run_command(CMD_READ, 8'h00, 1'b0, 8'hFF, 1'b0);
    run_command(CMD_READ, 8'h00, 1'b1, 8'h00, 1'b0);
    run_command(CMD_WRITE, 8'h5A, 1'b1, 8'h00, 1'b0);
    run_command(CMD_WRITE, m_crc, 1'b0, 8'h00, 1'b0);
    run_command(CMD_WRITE, 8'hA7, 1'b0, 8'h00, 1'b0);
    run_command(CMD_READ, 8'h00, 1'b0, m_crc, 1'b0);
    idle_ticks(2);
  endtask

  // Mostly well-formed commands on short random timings; CRC bytes are fed
  // back often so frame checks pass. Some idle words, unused-mode starts and
  // line noise at the sample points mixed in.
  task automatic test_random_traffic();
    int unsigned first_tick;
    int unsigned round_mark;
    int          pick;
    cmd_e        cmd;
    logic [7:0]  payload;
    logic [7:0]  target;
    bit          paused;
    first_tick = busy_ticks;
    round_mark = busy_ticks;
    paused     = 1'b0;
    load_timing(short_timing());
    while (busy_ticks - first_tick < RandomTicks) begin
      if (busy_ticks - round_mark >= RoundTicks) begin
        load_timing(short_timing());
        round_mark = busy_ticks;
      end
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        send_idle_on = 1'b1;
        idle_ticks($urandom_range(1, 4));
      end else if (pick == 2) begin
        run_command(CMD_UNUSED, 8'($urandom), 1'($urandom_range(0, 1)), 8'h00, 1'b0);
      end else begin
        cmd       = cmd_e'($urandom_range(0, 2));
        payload   = ($urandom_range(0, 2) == 0) ? m_crc : 8'($urandom);
        target    = ($urandom_range(0, 2) == 0) ? m_crc : 8'($urandom);
        bus_noise = ($urandom_range(0, 9) == 0);
        run_command(cmd, payload, ($urandom_range(0, 3) == 0), target,
                    !paused || ($urandom_range(0, 15) == 0));
        paused    = 1'b1;
        bus_noise = 1'b0;
      end
    end
  endtask

  // Run time limit
  initial begin : watchdog
    #(WatchdogNs);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : main_seq
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_RESET_LOW;
    cfg_wdata_i  = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    err_count    = 0;
    result_count = 0;
    busy_ticks   = 0;
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    bus_noise    = 1'b0;
    bus_target   = '0;
    shadow_reset();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_power_on_defaults();
    test_short_timing();
    test_random_traffic();

    drain_results();
    repeat (TailTicks) @(negedge clk_i);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
design/owbm_pkg.sv
design/owbm_if.sv
design/owbm_cfg_regs.sv
design/owbm_engine.sv
design/one_wire_byte_master_crc8_core.sv
sim/tb_top.sv
